### rtl/core/pts_pkg.sv
package pts_pkg;

  localparam int THREAD_SLOTS_DEF = 16;
  localparam int KIND_W           = 3;
  localparam int PRIO_W           = 8;
  localparam int PORT_ID_W        = 4;
  localparam int STATUS_W         = 2;

  localparam logic [PRIO_W-1:0] IDLE_PRIO_RST = 8'd99;

  // request kinds
  localparam logic [KIND_W-1:0] K_CREATE = 3'd0;
  localparam logic [KIND_W-1:0] K_SCHED  = 3'd1;
  localparam logic [KIND_W-1:0] K_EXIT   = 3'd2;
  localparam logic [KIND_W-1:0] K_KILL   = 3'd3;
  localparam logic [KIND_W-1:0] K_REAP   = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ID     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic scan;
    logic mark;
    logic reap;
  } pts_map_cmd_t;

  typedef struct packed {
    logic done;
    logic found;
  } pts_map_stat_t;

endpackage

### rtl/core/pts_id_map.sv
module pts_id_map
  import pts_pkg::*;
#(
  parameter int THREAD_SLOTS = THREAD_SLOTS_DEF,
  localparam int ID_W = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  pts_map_cmd_t  cmd,
  input  logic [ID_W-1:0] dead_id,
  output pts_map_stat_t stat,
  output logic [ID_W-1:0] free_id
);

  logic [THREAD_SLOTS-1:0] taken;
  logic [THREAD_SLOTS-1:0] dead;
  logic                    scanning;
  logic [ID_W-1:0]         idx;

  // lowest free id search walks one slot per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      taken      <= THREAD_SLOTS'(1);
      dead       <= '0;
      scanning   <= 1'b0;
      idx        <= '0;
      stat       <= '0;
      free_id    <= '0;
    end else begin
      stat <= '0;
      if (cmd.scan) begin
        scanning <= 1'b1;
        idx      <= '0;
      end else if (scanning) begin
        if (!taken[idx]) begin
          taken[idx] <= 1'b1;
          free_id    <= idx;
          stat.done  <= 1'b1;
          stat.found <= 1'b1;
          scanning   <= 1'b0;
        end else if (idx == ID_W'(THREAD_SLOTS - 1)) begin
          stat.done <= 1'b1;
          scanning  <= 1'b0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      if (cmd.mark) begin
        dead[dead_id] <= 1'b1;
      end
      if (cmd.reap) begin
        taken <= taken & ~dead;
        dead  <= '0;
      end
    end
  end

endmodule

### rtl/core/priority_thread_scheduler.sv
// create: the id search, then an insert that shifts queue entries up from the tail;
// schedule pops the head and puts back the running thread; empty queue gets an idle thread first
// kill searches the queue and closes the gap, reap and unknown kinds go straight to the result
// throughput: one item at a time, set by the queue memory walk (one read and one write port)
// reset: synchronous; slot 0 taken and running, queue empty, idle priority 99
module priority_thread_scheduler
  import pts_pkg::*;
#(
  parameter int THREAD_SLOTS = THREAD_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   kind,
  input  logic [PRIO_W-1:0]   priority_req,
  input  logic [PORT_ID_W-1:0] thread_id,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [PORT_ID_W-1:0] allocated_id,
  output logic                allocated_valid,
  output logic                switched,
  output logic [PORT_ID_W-1:0] running_id,
  output logic                running_valid,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PRIO_W-1:0]   cfg_data
);

  localparam int ID_W  = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int CNT_W = $clog2(THREAD_SLOTS + 1);
  localparam int CW    = (ID_W > PORT_ID_W) ? ID_W : PORT_ID_W;
  localparam int ENT_W = PRIO_W + ID_W;

  typedef enum logic [3:0] {
    S_IDLE, S_EXIT, S_SCHED, S_ALLOC, S_ALLOC_WAIT, S_INS_RD, S_INS_EV,
    S_POP_RD, S_POP_EV, S_REM_RD, S_REM_EV, S_PUT, S_SWITCH,
    S_KILL_RD, S_KILL_EV, S_DONE
  } state_t;

  state_t state;
  state_t ret;

  logic [ENT_W-1:0] mem [THREAD_SLOTS];
  logic [ENT_W-1:0] rd;
  logic             mem_we;
  logic [ID_W-1:0]  mem_wa;
  logic [ID_W-1:0]  mem_ra;
  logic [ENT_W-1:0] mem_wd;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    k;
  logic [CNT_W-1:0]    km1;
  logic [CNT_W-1:0]    kp1;
  logic [ID_W-1:0]     cur_id;
  logic [PRIO_W-1:0]   cur_prio;
  logic                cur_valid;
  logic [PRIO_W-1:0]   idle_prio;
  logic [ID_W-1:0]     head_id;
  logic [PRIO_W-1:0]   head_prio;
  logic [ID_W-1:0]     ins_id;
  logic [PRIO_W-1:0]   ins_prio;
  logic [PRIO_W-1:0]   prio_q;
  logic [PORT_ID_W-1:0] tid_q;
  logic                is_idle;
  logic [STATUS_W-1:0] st;
  logic [ID_W-1:0]     a_id;
  logic                a_v;
  logic                sw;

  logic [ID_W-1:0]   rd_id;
  logic [PRIO_W-1:0] rd_prio;
  logic [CW-1:0]     rd_ext;
  logic [CW-1:0]     tid_ext;
  logic [CW-1:0]     cur_ext;
  logic [CW-1:0]     a_ext;
  logic              ins_before;

  pts_map_cmd_t  map_cmd;
  pts_map_stat_t map_stat;
  logic [ID_W-1:0] free_id;

  assign km1        = k - 1'b1;
  assign kp1        = k + 1'b1;
  assign rd_id      = rd[ID_W-1:0];
  assign rd_prio    = rd[ENT_W-1:ID_W];
  assign rd_ext     = CW'(rd_id);
  assign tid_ext    = CW'(tid_q);
  assign cur_ext    = CW'(cur_id);
  assign a_ext      = CW'(a_id);
  assign ins_before = ins_prio < rd_prio;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign map_cmd.scan = (state == S_ALLOC);
  assign map_cmd.mark = (state == S_EXIT) && cur_valid;
  assign map_cmd.reap = (state == S_IDLE) && in_valid && (kind == K_REAP);

  pts_id_map #(.THREAD_SLOTS(THREAD_SLOTS)) u_map (
    .clk     (clk),
    .rst     (rst),
    .cmd     (map_cmd),
    .dead_id (cur_id),
    .stat    (map_stat),
    .free_id (free_id)
  );

  // queue memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = {ins_prio, ins_id};
    mem_ra = '0;
    case (state)
      S_INS_RD: begin
        if (k == '0) begin
          mem_we = 1'b1;
        end else begin
          mem_ra = km1[ID_W-1:0];
        end
      end
      S_INS_EV: begin
        mem_we = 1'b1;
        mem_wa = k[ID_W-1:0];
        if (ins_before) begin
          mem_wd = rd;
        end
      end
      S_REM_RD:  mem_ra = kp1[ID_W-1:0];
      S_REM_EV: begin
        mem_we = 1'b1;
        mem_wa = k[ID_W-1:0];
        mem_wd = rd;
      end
      S_KILL_RD: mem_ra = k[ID_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      ret             <= S_DONE;
      count           <= '0;
      k               <= '0;
      cur_id          <= '0;
      cur_prio        <= '0;
      cur_valid       <= 1'b1;
      idle_prio       <= IDLE_PRIO_RST;
      is_idle         <= 1'b0;
      st              <= ST_OK;
      a_v             <= 1'b0;
      sw              <= 1'b0;
      out_valid       <= 1'b0;
      status          <= ST_OK;
      allocated_id    <= '0;
      allocated_valid <= 1'b0;
      switched        <= 1'b0;
      running_id      <= '0;
      running_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        idle_prio <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            prio_q  <= priority_req;
            tid_q   <= thread_id;
            is_idle <= (kind != K_CREATE);
            st      <= ST_OK;
            a_id    <= '0;
            a_v     <= 1'b0;
            sw      <= 1'b0;
            k       <= '0;
            case (kind)
              K_CREATE: state <= S_ALLOC;
              K_SCHED:  state <= S_SCHED;
              K_EXIT:   state <= S_EXIT;
              K_KILL:   state <= S_KILL_RD;
              default:  state <= S_DONE;
            endcase
          end
        end
        S_EXIT: begin
          cur_valid <= 1'b0;
          state     <= S_SCHED;
        end
        S_SCHED: begin
          state <= (count == '0) ? S_ALLOC : S_POP_RD;
        end
        S_ALLOC: state <= S_ALLOC_WAIT;
        S_ALLOC_WAIT: begin
          if (map_stat.done) begin
            if (map_stat.found) begin
              a_id     <= free_id;
              a_v      <= 1'b1;
              ins_id   <= free_id;
              ins_prio <= is_idle ? idle_prio : prio_q;
              ret      <= is_idle ? S_POP_RD : S_DONE;
              k        <= count;
              state    <= S_INS_RD;
            end else begin
              st    <= ST_NO_ID;
              state <= S_DONE;
            end
          end
        end
        // insertion walks from the tail, shifting larger priorities up
        S_INS_RD: begin
          if (k == '0) begin
            count <= count + 1'b1;
            state <= ret;
          end else begin
            state <= S_INS_EV;
          end
        end
        S_INS_EV: begin
          if (ins_before) begin
            k     <= km1;
            state <= S_INS_RD;
          end else begin
            count <= count + 1'b1;
            state <= ret;
          end
        end
        S_POP_RD: state <= S_POP_EV;
        S_POP_EV: begin
          head_id   <= rd_id;
          head_prio <= rd_prio;
          k         <= '0;
          ret       <= S_PUT;
          state     <= S_REM_RD;
        end
        // removal closes the gap at k by shifting later entries down
        S_REM_RD: begin
          if (kp1 < count) begin
            state <= S_REM_EV;
          end else begin
            count <= count - 1'b1;
            state <= ret;
          end
        end
        S_REM_EV: begin
          k     <= kp1;
          state <= S_REM_RD;
        end
        S_PUT: begin
          if (cur_valid) begin
            ins_id   <= cur_id;
            ins_prio <= cur_prio;
            k        <= count;
            ret      <= S_SWITCH;
            state    <= S_INS_RD;
          end else begin
            state <= S_SWITCH;
          end
        end
        S_SWITCH: begin
          cur_id    <= head_id;
          cur_prio  <= head_prio;
          cur_valid <= 1'b1;
          sw        <= 1'b1;
          state     <= S_DONE;
        end
        S_KILL_RD: begin
          if (k < count) begin
            state <= S_KILL_EV;
          end else begin
            st    <= ST_NOT_FOUND;
            state <= S_DONE;
          end
        end
        S_KILL_EV: begin
          if (rd_ext == tid_ext) begin
            ret   <= S_DONE;
            state <= S_REM_RD;
          end else begin
            k     <= kp1;
            state <= S_KILL_RD;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            status          <= st;
            allocated_id    <= a_v ? a_ext[PORT_ID_W-1:0] : '0;
            allocated_valid <= a_v;
            switched        <= sw;
            running_id      <= cur_valid ? cur_ext[PORT_ID_W-1:0] : '0;
            running_valid   <= cur_valid;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/pts_checker.sv
module pts_checker
  import pts_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [STATUS_W-1:0]  status,
  input logic [PORT_ID_W-1:0] allocated_id,
  input logic                 allocated_valid,
  input logic                 switched,
  input logic [PORT_ID_W-1:0] running_id,
  input logic                 running_valid
);

  // one item at a time: a transfer in makes the block busy next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  a_switch_runs: assert property (@(posedge clk) disable iff (rst)
    out_valid && switched |-> running_valid && (status == ST_OK))
    else $error("switch reported without a running thread");

  a_alloc_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !allocated_valid |-> (allocated_id == '0))
    else $error("allocated id set without allocation");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(running_id)
      && $stable(switched) && $stable(allocated_id))
    else $error("stalled result changed");

endmodule

bind priority_thread_scheduler pts_checker u_pts_checker (.*);
